/* design/assert_macros.svh */
// Assertion macros used by the checker file of the list engine.
// Depends on nothing; each macro wraps one clocked, reset-qualified property.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain assertion with a fixed message.
`define OLAE_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("olae assertion failed");

// Assertion with a message of the caller's choosing.
`define OLAE_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

`endif

/* design/olae_pkg.sv */
// Package of the ordered list engine: request and status codes, cell control types.
// Depends on nothing; the engine, cell, sequencer, checker and testbench import it.
package olae_pkg;

    localparam int OLAE_DEPTH = 128;
    localparam int WORD_W     = 32;
    localparam int POS_W      = 11;

    typedef enum logic [2:0] {
        REQ_APPEND       = 3'd0,
        REQ_INSERT       = 3'd1,
        REQ_REMOVE_VALUE = 3'd2,
        REQ_REMOVE_AT    = 3'd3,
        REQ_SEARCH       = 3'd4,
        REQ_READ         = 3'd5
    } t_req;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BADPOS   = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic              tok_start;
        logic              tok_clr;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] data;
    } t_cell_ctl;

    typedef struct packed {
        logic              hit;
        logic [WORD_W-1:0] data;
    } t_cell_status;

endpackage

/* design/olae_if.sv */
// Valid/ready channel interfaces for the request and result beats of the list engine.
// Depends on nothing.
interface olae_req_if;
    logic              valid;
    logic              ready;
    logic [2:0]        req_type;
    logic signed [31:0] value;
    logic [7:0]        position;

    modport source (output valid, output req_type, output value, output position,
                    input ready);
    modport sink (input valid, input req_type, input value, input position,
                  output ready);
endinterface

interface olae_rsp_if;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [6:0]        found_index;
    logic signed [31:0] read_value;
    logic [7:0]        item_total;

    modport source (output valid, output status, output found_index, output read_value,
                    output item_total, input ready);
    modport sink (input valid, input status, input found_index, input read_value,
                  input item_total, output ready);
endinterface

/* design/ordered_array_list_engine.sv */
// Top level of the ordered list engine: sequencer plus a row of DEPTH word cells.
// Depends on olae_pkg, olae_if, olae_cell and olae_ctrl.
//
//   channel   direction   beat contents
//   i_req     in          req_type, value, position
//   o_rsp     out         status, found_index, read_value, item_total
//
// Append, insert, remove at a position and every rejected request finish without a scan.
// Search and remove by value scan until a match at index k, or up to count when there is
// none; a read scans up to its position. A scan token walks the cell row
// one cell per cycle, and that walk sets how long these requests take.
// Reset clears the state, count, result flag and tokens only; no clearing pass is run.
// A request is taken while a result beat is being handed over; a stalled result
// blocks new requests.
module ordered_array_list_engine import olae_pkg::*; #(
    parameter int DEPTH = OLAE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    olae_req_if.sink   i_req,
    olae_rsp_if.source o_rsp
);

    t_cell_ctl    w_ctl;
    t_cell_status w_status;
    logic [DEPTH-1:0][WORD_W-1:0] w_word;
    logic [DEPTH-1:0][WORD_W-1:0] w_data;
    logic [DEPTH-1:0]             w_tok;
    logic [DEPTH-1:0]             w_hit;

    olae_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_req.valid),
        .o_req_ready   (i_req.ready),
        .i_req_type    (i_req.req_type),
        .i_value       (i_req.value),
        .i_position    (i_req.position),
        .i_cells       (w_status),
        .o_ctl         (w_ctl),
        .o_rsp_valid   (o_rsp.valid),
        .i_rsp_ready   (o_rsp.ready),
        .o_status      (o_rsp.status),
        .o_found_index (o_rsp.found_index),
        .o_read_value  (o_rsp.read_value),
        .o_item_total  (o_rsp.item_total)
    );

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic              w_tok_in;
        logic [WORD_W-1:0] w_lo;
        logic [WORD_W-1:0] w_hi;

        if (i == 0) begin : g_first
            assign w_tok_in = w_ctl.tok_start;
            assign w_lo     = '0;
        end else begin : g_rest
            assign w_tok_in = w_tok[i-1];
            assign w_lo     = w_word[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign w_hi = '0;
        end else begin : g_inner
            assign w_hi = w_word[i+1];
        end

        olae_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_index   (POS_W'(i)),
            .i_tok     (w_tok_in),
            .i_lo_word (w_lo),
            .i_hi_word (w_hi),
            .o_word    (w_word[i]),
            .o_tok     (w_tok[i]),
            .o_hit     (w_hit[i]),
            .o_data    (w_data[i])
        );
    end

    always_comb begin
        logic [WORD_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < DEPTH; k++) begin
            acc = acc | w_data[k];
        end
        w_status.hit  = |w_hit;
        w_status.data = acc;
    end

endmodule

/* design/olae_cell.sv */
// One cell of the list row: a stored word, a scan token and the shift logic.
// Depends on olae_pkg for the cell control and word types.
module olae_cell import olae_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  logic [POS_W-1:0]  i_index,
    input  logic              i_tok,
    input  logic [WORD_W-1:0] i_lo_word,
    input  logic [WORD_W-1:0] i_hi_word,
    output logic [WORD_W-1:0] o_word,
    output logic              o_tok,
    output logic              o_hit,
    output logic [WORD_W-1:0] o_data
);

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;
    logic              r_tok;
    logic              n_tok;

    always_comb begin
        n_word = r_word;
        n_tok  = i_ctl.tok_clr ? 1'b0 : i_tok;
        case (i_ctl.op)
            CELL_INSERT: begin
                if (i_index == i_ctl.pos) begin
                    n_word = i_ctl.data;
                end else if (i_index > i_ctl.pos) begin
                    n_word = i_lo_word;
                end
            end
            CELL_REMOVE: begin
                if (i_index >= i_ctl.pos) begin
                    n_word = i_hi_word;
                end
            end
            CELL_HOLD: begin
                n_word = r_word;
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_word = r_word;
    assign o_tok  = r_tok;
    assign o_hit  = r_tok && (r_word == i_ctl.data);
    assign o_data = r_tok ? r_word : '0;

endmodule

/* design/olae_ctrl.sv */
// Sequencer of the list engine: decodes requests, keeps the count, steers the cell row
// and holds the result register. Depends on olae_pkg.
module olae_ctrl import olae_pkg::*; #(
    parameter int DEPTH = OLAE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_req_valid,
    output logic         o_req_ready,
    input  logic [2:0]   i_req_type,
    input  logic [31:0]  i_value,
    input  logic [7:0]   i_position,
    input  t_cell_status i_cells,
    output t_cell_ctl    o_ctl,
    output logic         o_rsp_valid,
    input  logic         i_rsp_ready,
    output logic [1:0]   o_status,
    output logic [6:0]   o_found_index,
    output logic [31:0]  o_read_value,
    output logic [7:0]   o_item_total
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > 8) ? CW : 8;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state      r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_scan, n_scan;
    logic [CW-1:0] r_pos, n_pos;
    t_req        r_op, n_op;
    logic [31:0] r_key, n_key;
    logic        r_out_valid, n_out_valid;
    t_status     r_status, n_status;
    logic [6:0]  r_found, n_found;
    logic [31:0] r_rdata, n_rdata;
    logic [7:0]  r_total, n_total;

    logic        w_acc;
    logic        w_fin;
    logic        w_full;
    logic [PW-1:0] w_pos;
    logic [PW-1:0] w_cnt;
    t_status     w_status;
    logic [6:0]  w_found;
    logic [31:0] w_rdata;

    assign o_req_ready = (r_state == S_IDLE) && (!r_out_valid || i_rsp_ready);
    assign w_acc  = i_req_valid && o_req_ready;
    assign w_full = (r_count == CW'(DEPTH));
    assign w_pos  = PW'(i_position);
    assign w_cnt  = PW'(r_count);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_scan      = r_scan;
        n_pos       = r_pos;
        n_op        = r_op;
        n_key       = r_key;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_found     = r_found;
        n_rdata     = r_rdata;
        n_total     = r_total;
        w_fin       = 1'b0;
        w_status    = ST_OK;
        w_found     = '0;
        w_rdata     = '0;
        o_ctl.op        = CELL_HOLD;
        o_ctl.tok_start = 1'b0;
        o_ctl.tok_clr   = 1'b0;
        o_ctl.pos       = '0;
        o_ctl.data      = r_key;

        if (r_out_valid && i_rsp_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    o_ctl.data = i_value;
                    n_key      = i_value;
                    n_op       = t_req'(i_req_type);
                    n_pos      = CW'(i_position);
                    n_scan     = '0;
                    w_fin      = 1'b1;
                    case (t_req'(i_req_type))
                        REQ_APPEND: begin
                            if (w_full) begin
                                w_status = ST_FULL;
                            end else begin
                                o_ctl.op  = CELL_INSERT;
                                o_ctl.pos = POS_W'(r_count);
                                n_count   = r_count + 1'b1;
                            end
                        end
                        REQ_INSERT: begin
                            if (w_full) begin
                                w_status = ST_FULL;
                            end else if (w_pos > w_cnt) begin
                                w_status = ST_BADPOS;
                            end else begin
                                o_ctl.op  = CELL_INSERT;
                                o_ctl.pos = POS_W'(w_pos);
                                n_count   = r_count + 1'b1;
                            end
                        end
                        REQ_REMOVE_AT: begin
                            if (w_pos >= w_cnt) begin
                                w_status = ST_BADPOS;
                            end else begin
                                o_ctl.op  = CELL_REMOVE;
                                o_ctl.pos = POS_W'(w_pos);
                                n_count   = r_count - 1'b1;
                            end
                        end
                        REQ_REMOVE_VALUE, REQ_SEARCH: begin
                            o_ctl.tok_start = 1'b1;
                            n_state         = S_SCAN;
                            w_fin           = 1'b0;
                        end
                        REQ_READ: begin
                            if (w_pos >= w_cnt) begin
                                w_status = ST_BADPOS;
                            end else begin
                                o_ctl.tok_start = 1'b1;
                                n_state         = S_SCAN;
                                w_fin           = 1'b0;
                            end
                        end
                        default: begin
                            w_status = ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                case (r_op)
                    REQ_READ: begin
                        if (r_scan == r_pos) begin
                            w_rdata       = i_cells.data;
                            o_ctl.tok_clr = 1'b1;
                            w_fin         = 1'b1;
                        end else begin
                            n_scan = r_scan + 1'b1;
                        end
                    end
                    default: begin
                        if (r_scan >= r_count) begin
                            w_status      = ST_NOTFOUND;
                            o_ctl.tok_clr = 1'b1;
                            w_fin         = 1'b1;
                        end else if (i_cells.hit) begin
                            o_ctl.tok_clr = 1'b1;
                            w_fin         = 1'b1;
                            if (r_op == REQ_REMOVE_VALUE) begin
                                o_ctl.op  = CELL_REMOVE;
                                o_ctl.pos = POS_W'(r_scan);
                                n_count   = r_count - 1'b1;
                            end else begin
                                w_found = 7'(r_scan);
                            end
                        end else begin
                            n_scan = r_scan + 1'b1;
                        end
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_fin) begin
            n_state     = S_IDLE;
            n_out_valid = 1'b1;
            n_status    = w_status;
            n_found     = w_found;
            n_rdata     = w_rdata;
            n_total     = 8'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan   <= n_scan;
        r_pos    <= n_pos;
        r_op     <= n_op;
        r_key    <= n_key;
        r_status <= n_status;
        r_found  <= n_found;
        r_rdata  <= n_rdata;
        r_total  <= n_total;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_rsp_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_found_index = r_found;
    assign o_read_value  = r_rdata;
    assign o_item_total  = r_total;

endmodule

/* design/olae_checker.sv */
// Port-level checker of the ordered list engine and its bind to the top level.
// Depends on olae_pkg and assert_macros.svh.
`include "assert_macros.svh"

module olae_checker import olae_pkg::*; #(
    parameter int DEPTH = OLAE_DEPTH
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [1:0]  i_status,
    input logic [6:0]  i_found_index,
    input logic [31:0] i_read_value,
    input logic [7:0]  i_item_total
);

    // A stalled result beat keeps its contents.
    `OLAE_ASSERT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable({i_status, i_found_index, i_read_value, i_item_total}))

    `OLAE_ASSERT_MSG(a_fail_zero, i_clk, i_rst_n, i_rsp_valid && (i_status != ST_OK) |-> (i_found_index == 7'd0) && (i_read_value == 32'd0), "failed request carries data")

    `OLAE_ASSERT_MSG(a_full_total, i_clk, i_rst_n, i_rsp_valid && (i_status == ST_FULL) |-> (i_item_total == 8'(DEPTH)), "full status with short list")

    `OLAE_ASSERT_MSG(a_total_range, i_clk, i_rst_n, i_rsp_valid |-> (32'(i_item_total) <= 32'(DEPTH)), "count beyond depth")

endmodule

bind ordered_array_list_engine olae_checker #(.DEPTH(DEPTH)) u_olae_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_status      (o_rsp.status),
    .i_found_index (o_rsp.found_index),
    .i_read_value  (o_rsp.read_value),
    .i_item_total  (o_rsp.item_total)
);

/* test/tb_ordered_array_list_engine.sv */
// Self-checking testbench for ordered_array_list_engine: directed, full-list, back-pressure
// and random request beats. Depends on olae_pkg, olae_if and the engine's RTL.
module tb_ordered_array_list_engine;
    import olae_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = OLAE_DEPTH;
    localparam int HOLD_LEN = 80;
    localparam logic [2:0] REQ_SPARE_LO = 3'd6;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;

    typedef struct {
        t_status            status;
        logic [6:0]         found_index;
        logic signed [31:0] read_value;
        logic [7:0]         item_total;
    } t_list_result;

    logic i_clk;
    logic i_rst_n;

    olae_req_if req_if ();
    olae_rsp_if rsp_if ();

    ordered_array_list_engine u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    logic signed [31:0] list_words [DEPTH];
    int                 list_len = 0;
    t_list_result       awaited_results [$];
    int                 error_count = 0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 hold_cycles = 0;
    int                 hold_asks = 0;
    int                 hold_taken = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int first_index_of(logic signed [31:0] v);
        int k;
        for (k = 0; k < list_len; k++) begin
            if (list_words[k] == v) begin
                return k;
            end
        end
        return -1;
    endfunction

    function automatic void drop_entry(int at);
        int k;
        for (k = at; k + 1 < list_len; k++) begin
            list_words[k] = list_words[k + 1];
        end
        list_len--;
    endfunction

    function automatic t_list_result apply_list_request(logic [2:0] kind,
                                                       logic signed [31:0] value,
                                                       logic [7:0] position);
        t_list_result res;
        int           idx;
        int           k;
        res.status      = ST_OK;
        res.found_index = '0;
        res.read_value  = '0;
        case (kind)
            REQ_APPEND: begin
                if (list_len >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    list_words[list_len] = value;
                    list_len++;
                end
            end
            REQ_INSERT: begin
                if (list_len >= DEPTH) begin
                    res.status = ST_FULL;
                end else if (position > list_len) begin
                    res.status = ST_BADPOS;
                end else begin
                    for (k = list_len; k > position; k--) begin
                        list_words[k] = list_words[k - 1];
                    end
                    list_words[position] = value;
                    list_len++;
                end
            end
            REQ_REMOVE_VALUE: begin
                idx = first_index_of(value);
                if (idx < 0) begin
                    res.status = ST_NOTFOUND;
                end else begin
                    drop_entry(idx);
                end
            end
            REQ_REMOVE_AT: begin
                if (position >= list_len) begin
                    res.status = ST_BADPOS;
                end else begin
                    drop_entry(int'(position));
                end
            end
            REQ_SEARCH: begin
                idx = first_index_of(value);
                if (idx < 0) begin
                    res.status = ST_NOTFOUND;
                end else begin
                    res.found_index = idx[6:0];
                end
            end
            REQ_READ: begin
                if (position >= list_len) begin
                    res.status = ST_BADPOS;
                end else begin
                    res.read_value = list_words[position];
                end
            end
            default: ;
        endcase
        res.item_total = list_len[7:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, longint want_v, longint got_v);
        $display("[%0t] %s: expected %0d, got %0d", $realtime, what, want_v, got_v);
        error_count++;
    endtask

    task automatic check_result();
        t_list_result want;
        if (awaited_results.size() == 0) begin
            report_mismatch("result beat with none pending, item_total", 0, rsp_if.item_total);
            return;
        end
        want = awaited_results.pop_front();
        if (rsp_if.status !== want.status)
            report_mismatch("status", want.status, rsp_if.status);
        if (rsp_if.found_index !== want.found_index)
            report_mismatch("found_index", want.found_index, rsp_if.found_index);
        if (rsp_if.read_value !== want.read_value)
            report_mismatch("read_value", want.read_value, rsp_if.read_value);
        if (rsp_if.item_total !== want.item_total)
            report_mismatch("item_total", want.item_total, rsp_if.item_total);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready)
                awaited_results.push_back(apply_list_request(req_if.req_type, req_if.value,
                                                             req_if.position));
            if (rsp_if.valid && rsp_if.ready)
                check_result();
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (hold_taken != hold_asks) begin
            rsp_if.ready <= 1'b0;
            hold_taken   <= hold_asks;
            hold_cycles  <= HOLD_LEN - 1;
        end else if (hold_cycles != 0) begin
            rsp_if.ready <= 1'b0;
            hold_cycles  <= hold_cycles - 1;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_request(logic [2:0] kind, logic signed [31:0] value,
                                logic [7:0] position);
        if ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        req_if.valid    <= 1'b1;
        req_if.req_type <= kind;
        req_if.value    <= value;
        req_if.position <= position;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic wait_results_settled(int extra_cycles);
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
        repeat (extra_cycles) @(posedge i_clk);
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    function automatic logic signed [31:0] pick_word();
        int roll;
        roll = $urandom_range(9);
        if (roll < 4 && list_len > 0)
            return list_words[$urandom_range(list_len - 1)];
        if (roll < 7)
            return $signed($urandom_range(8)) - 4;
        return $urandom;
    endfunction

    task automatic send_random_request(int grow_pct);
        int                 roll;
        int                 len;
        logic [2:0]         kind;
        logic [7:0]         pos;
        len  = list_len;
        roll = $urandom_range(99);
        if (roll < 3)
            kind = $urandom_range(1) ? REQ_SPARE_HI : REQ_SPARE_LO;
        else if (roll < 3 + grow_pct)
            kind = ($urandom_range(99) < 40) ? REQ_APPEND : REQ_INSERT;
        else if (roll < 3 + grow_pct + (97 - grow_pct) / 2)
            kind = $urandom_range(1) ? REQ_REMOVE_VALUE : REQ_REMOVE_AT;
        else
            kind = $urandom_range(1) ? REQ_SEARCH : REQ_READ;
        if ($urandom_range(9) == 0)
            pos = 8'($urandom_range(255));
        else
            pos = 8'($urandom_range(len));
        send_request(kind, pick_word(), pos);
    endtask

    task automatic test_directed();
        send_request(REQ_READ, 32'sd0, 8'd0);
        send_request(REQ_REMOVE_AT, 32'sd0, 8'd0);
        send_request(REQ_REMOVE_VALUE, 32'sd5, 8'd0);
        send_request(REQ_SEARCH, 32'sd5, 8'd0);
        send_request(REQ_INSERT, 32'sd9, 8'd1);
        send_request(REQ_INSERT, 32'sh7FFF_FFFF, 8'd0);
        send_request(REQ_APPEND, 32'sh8000_0000, 8'd255);
        send_request(REQ_INSERT, 32'sd0, 8'd1);
        send_request(REQ_APPEND, -32'sd1, 8'd0);
        send_request(REQ_INSERT, 32'sd1, 8'd4);
        send_request(REQ_APPEND, 32'sd0, 8'd0);
        send_request(REQ_SEARCH, -32'sd1, 8'd0);
        send_request(REQ_SEARCH, 32'sh8000_0000, 8'd0);
        send_request(REQ_SEARCH, 32'sd0, 8'd0);
        send_request(REQ_READ, 32'sd0, 8'd0);
        send_request(REQ_READ, 32'sd0, 8'd5);
        send_request(REQ_READ, 32'sd0, 8'd6);
        send_request(REQ_READ, 32'sd0, 8'd255);
        send_request(REQ_REMOVE_AT, 32'sd0, 8'd255);
        send_request(REQ_SPARE_LO, 32'sh5555_AAAA, 8'd170);
        send_request(REQ_SPARE_HI, 32'shAAAA_5555, 8'd85);
        send_request(REQ_REMOVE_VALUE, 32'sd0, 8'd0);
        send_request(REQ_REMOVE_VALUE, 32'sh7FFF_FFFF, 8'd0);
        send_request(REQ_REMOVE_AT, 32'sd0, 8'd3);
        send_request(REQ_READ, 32'sd0, 8'd0);
        wait_results_settled(0);
    endtask

    task automatic test_full_list();
        logic signed [31:0] fill_base;
        int                 needed;
        int                 n;
        fill_base = 32'sh3C00_0000;
        needed    = DEPTH - list_len;
        for (n = 0; n < needed; n++)
            send_request(REQ_APPEND, fill_base + n, 8'($urandom_range(255)));
        send_request(REQ_APPEND, 32'sd7, 8'd0);
        send_request(REQ_INSERT, 32'sd7, 8'd0);
        send_request(REQ_INSERT, 32'sd7, 8'd255);
        send_request(REQ_SEARCH, fill_base + needed - 1, 8'd0);
        send_request(REQ_READ, 32'sd0, 8'd127);
        send_request(REQ_READ, 32'sd0, 8'd128);
        send_request(REQ_REMOVE_AT, 32'sd0, 8'd127);
        send_request(REQ_INSERT, 32'sh8000_0000, 8'd127);
        send_request(REQ_SEARCH, 32'sh8000_0000, 8'd0);
        send_request(REQ_REMOVE_VALUE, fill_base, 8'd0);
        send_request(REQ_REMOVE_AT, 32'sd0, 8'd0);
        wait_results_settled(0);
    endtask

    task automatic test_backpressure();
        int n;
        set_idling(0, 0);
        hold_asks++;
        for (n = 0; n < 16; n++)
            send_random_request(50);
        wait_results_settled(0);
    endtask

    task automatic test_random_traffic(int send_pct, int recv_pct, int grow_pct,
                                       int shrink_pct);
        int n;
        set_idling(send_pct, recv_pct);
        for (n = 0; n < 34; n++)
            send_random_request(grow_pct);
        for (n = 0; n < 30; n++)
            send_random_request(shrink_pct);
        wait_results_settled(0);
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        req_if.valid    <= 1'b0;
        req_if.req_type <= REQ_APPEND;
        req_if.value    <= '0;
        req_if.position <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_list();
        test_backpressure();
        test_random_traffic(0, 0, 65, 25);
        test_random_traffic(48, 0, 75, 20);
        test_random_traffic(0, 48, 55, 30);
        test_random_traffic(10, 10, 60, 25);
        test_backpressure();

        wait_results_settled(DEPTH + 8);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/olae_pkg.sv
design/olae_if.sv
design/olae_cell.sv
design/olae_ctrl.sv
design/ordered_array_list_engine.sv
design/olae_checker.sv
test/tb_ordered_array_list_engine.sv
